// ----- src/akpb_pkg.sv -----
`default_nettype none
package akpb_pkg;

    localparam int AKPB_MAX_DIM  = 4096;
    localparam int AKPB_PADDR_W  = 5;
    localparam int AKPB_PDATA_W  = 32;
    localparam int AKPB_DIM_REG_W = 13;
    localparam int AKPB_POS_W    = 12;
    localparam int AKPB_BPP_W    = 3;
    localparam int AKPB_ADDR_W   = 26;

    localparam logic [AKPB_BPP_W-1:0] AKPB_BPP_THREE = 3'd3;

    typedef enum logic [2:0] {
        REG_DEST_WIDTH  = 3'd0,
        REG_DEST_HEIGHT = 3'd1,
        REG_DEST_BPP    = 3'd2,
        REG_SRC_WIDTH   = 3'd3,
        REG_SRC_HEIGHT  = 3'd4,
        REG_PLACE_X     = 3'd5,
        REG_PLACE_Y     = 3'd6,
        REG_SWAP_RB     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [AKPB_DIM_REG_W-1:0] dest_width;
        logic [AKPB_DIM_REG_W-1:0] dest_height;
        logic [AKPB_BPP_W-1:0]     dest_bpp;
        logic [AKPB_DIM_REG_W-1:0] src_width;
        logic [AKPB_DIM_REG_W-1:0] src_height;
        logic [AKPB_POS_W-1:0]     place_x;
        logic [AKPB_POS_W-1:0]     place_y;
        logic                      swap_rb;
    } t_cfg;

    localparam t_cfg AKPB_CFG_RESET = '{
        dest_width:  13'd1,
        dest_height: 13'd1,
        dest_bpp:    3'd4,
        src_width:   13'd1,
        src_height:  13'd1,
        place_x:     12'd0,
        place_y:     12'd0,
        swap_rb:     1'b0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LIN,
        ST_SCALE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul;
        logic lin;
        logic scale;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ----- src/akpb_regs.sv -----
`default_nettype none
module akpb_regs (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [akpb_pkg::AKPB_PADDR_W-1:0]  paddr,
    input  wire  [akpb_pkg::AKPB_PDATA_W-1:0]  pwdata,
    output logic [akpb_pkg::AKPB_PDATA_W-1:0]  prdata,
    output logic                               pready,
    output akpb_pkg::t_cfg                     o_cfg
);
    import akpb_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[AKPB_PADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            case (idx)
                REG_DEST_WIDTH:  n_cfg.dest_width  = pwdata[AKPB_DIM_REG_W-1:0];
                REG_DEST_HEIGHT: n_cfg.dest_height = pwdata[AKPB_DIM_REG_W-1:0];
                REG_DEST_BPP:    n_cfg.dest_bpp    = pwdata[AKPB_BPP_W-1:0];
                REG_SRC_WIDTH:   n_cfg.src_width   = pwdata[AKPB_DIM_REG_W-1:0];
                REG_SRC_HEIGHT:  n_cfg.src_height  = pwdata[AKPB_DIM_REG_W-1:0];
                REG_PLACE_X:     n_cfg.place_x     = pwdata[AKPB_POS_W-1:0];
                REG_PLACE_Y:     n_cfg.place_y     = pwdata[AKPB_POS_W-1:0];
                REG_SWAP_RB:     n_cfg.swap_rb     = pwdata[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= AKPB_CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (idx)
            REG_DEST_WIDTH:  prdata = AKPB_PDATA_W'(r_cfg.dest_width);
            REG_DEST_HEIGHT: prdata = AKPB_PDATA_W'(r_cfg.dest_height);
            REG_DEST_BPP:    prdata = AKPB_PDATA_W'(r_cfg.dest_bpp);
            REG_SRC_WIDTH:   prdata = AKPB_PDATA_W'(r_cfg.src_width);
            REG_SRC_HEIGHT:  prdata = AKPB_PDATA_W'(r_cfg.src_height);
            REG_PLACE_X:     prdata = AKPB_PDATA_W'(r_cfg.place_x);
            REG_PLACE_Y:     prdata = AKPB_PDATA_W'(r_cfg.place_y);
            REG_SWAP_RB:     prdata = AKPB_PDATA_W'(r_cfg.swap_rb);
            default:         prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- src/akpb_ctrl.sv -----
`default_nettype none
module akpb_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  akpb_pkg::t_status i_status,
    output logic              o_stall,
    output akpb_pkg::t_cmd    o_cmd
);
    import akpb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_MUL;
            ST_MUL:   n_state = ST_LIN;
            ST_LIN:   n_state = ST_SCALE;
            ST_SCALE: n_state = ST_EMIT;
            ST_EMIT:  if (i_status.out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            ST_MUL:   o_cmd.mul   = 1'b1;
            ST_LIN:   o_cmd.lin   = 1'b1;
            ST_SCALE: o_cmd.scale = 1'b1;
            ST_EMIT:  o_cmd.load  = i_status.out_free;
            default:  o_stall     = 1'b1;
        endcase
    end

endmodule
`default_nettype wire

// ----- src/akpb_dpath.sv -----
`default_nettype none
module akpb_dpath #(
    parameter int MAX_DIM = akpb_pkg::AKPB_MAX_DIM
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  akpb_pkg::t_cfg                    i_cfg,
    input  akpb_pkg::t_cmd                    i_cmd,
    output akpb_pkg::t_status                 o_status,
    input  wire  [7:0]                        i_chan_first,
    input  wire  [7:0]                        i_chan_second,
    input  wire  [7:0]                        i_chan_third,
    input  wire  [7:0]                        i_alpha,
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic                              o_write_enable,
    output logic [akpb_pkg::AKPB_ADDR_W-1:0]  o_dest_address,
    output logic [7:0]                        o_out_byte0,
    output logic [7:0]                        o_out_byte1,
    output logic [7:0]                        o_out_byte2,
    output logic                              o_frame_last
);
    import akpb_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int CMP_W  = (DIM_W > AKPB_DIM_REG_W) ? DIM_W : AKPB_DIM_REG_W;
    localparam int SUM_W  = ((CNT_W > AKPB_POS_W) ? CNT_W : AKPB_POS_W) + 1;
    localparam int P_W    = DIM_W + SUM_W;
    localparam int LIN_W  = P_W + 1;
    localparam int ADR_W  = LIN_W + 2;
    localparam int AREA_W = 2 * DIM_W;
    localparam int LIM_W  = AREA_W + 2;
    localparam int WIDE_W = (ADR_W > LIM_W) ? ADR_W : LIM_W;
    localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIM);

    logic [DIM_W-1:0] dw, dh, sw, sh;
    logic             bpp3;

    // size registers: zero acts as one, above the maximum clamps to it
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [AKPB_DIM_REG_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (w == '0)
            return DIM_W'(1);
        else if (w > DIM_MAX)
            return DIM_W'(DIM_MAX);
        else
            return DIM_W'(w);
    endfunction

    assign dw   = clamp_dim(i_cfg.dest_width);
    assign dh   = clamp_dim(i_cfg.dest_height);
    assign sw   = clamp_dim(i_cfg.src_width);
    assign sh   = clamp_dim(i_cfg.src_height);
    assign bpp3 = (i_cfg.dest_bpp == AKPB_BPP_THREE);

    // raster counters
    logic [CNT_W-1:0] r_col, r_row, n_col, n_row;
    logic [CNT_W:0]   col_inc, row_inc;
    logic             col_end, row_end;

    assign col_inc = {1'b0, r_col} + (CNT_W+1)'(1);
    assign row_inc = {1'b0, r_row} + (CNT_W+1)'(1);
    assign col_end = col_inc >= (CNT_W+1)'(sw);
    assign row_end = row_inc >= (CNT_W+1)'(sh);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cmd.accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : row_inc[CNT_W-1:0];
            end else begin
                n_col = col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // beat capture
    logic [7:0]       r_c0, r_c1, r_c2, r_alpha;
    logic [CNT_W-1:0] r_col_s, r_row_s;
    logic             r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_c0    <= i_chan_first;
            r_c1    <= i_chan_second;
            r_c2    <= i_chan_third;
            r_alpha <= i_alpha;
            r_col_s <= r_col;
            r_row_s <= r_row;
            r_last  <= col_end && row_end;
        end
    end

    // address arithmetic, one step per state
    logic [SUM_W-1:0]  row_sum;
    logic [P_W-1:0]    r_prod;
    logic [AREA_W-1:0] r_area;
    logic [LIN_W-1:0]  r_lin;
    logic [ADR_W-1:0]  lin_x, r_addr;
    logic [LIM_W-1:0]  area_x, r_limit;

    assign row_sum = SUM_W'(i_cfg.place_y) + SUM_W'(r_row_s);
    assign lin_x   = ADR_W'(r_lin);
    assign area_x  = LIM_W'(r_area);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= P_W'(dw) * P_W'(row_sum);
            r_area <= AREA_W'(dw) * AREA_W'(dh);
        end
        if (i_cmd.lin) begin
            r_lin <= LIN_W'(r_prod) + LIN_W'(i_cfg.place_x) + LIN_W'(r_col_s);
        end
        if (i_cmd.scale) begin
            // x3 as x + 2x, x4 as a shift
            r_addr  <= bpp3 ? (lin_x + (lin_x << 1)) : (lin_x << 2);
            r_limit <= bpp3 ? (area_x + (area_x << 1)) : (area_x << 2);
        end
    end

    // output register
    logic r_out_valid;
    logic en;

    assign en = (WIDE_W'(r_addr) < WIDE_W'(r_limit)) && (r_alpha != 8'd0);
    assign o_status.out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_write_enable <= en;
            o_dest_address <= en ? AKPB_ADDR_W'(r_addr) : '0;
            o_out_byte0    <= en ? (i_cfg.swap_rb ? r_c2 : r_c0) : 8'd0;
            o_out_byte1    <= en ? r_c1 : 8'd0;
            o_out_byte2    <= en ? (i_cfg.swap_rb ? r_c0 : r_c2) : 8'd0;
            o_frame_last   <= r_last;
        end
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

// ----- src/alpha_keyed_pixel_blit_top.sv -----
// The controller walks each pixel through multiply, add, scale and compare
// steps; the emit step waits while the output is stalled, and no new pixel is
// accepted until the result is loaded into the output register.
// Reset (i_rst_n low at a clock edge): config registers take reset values,
// the raster counters go to zero and the output register empties.
`default_nettype none
module alpha_keyed_pixel_blit_top #(
    parameter int MAX_DIM = akpb_pkg::AKPB_MAX_DIM
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [akpb_pkg::AKPB_PADDR_W-1:0]  paddr,
    input  wire  [akpb_pkg::AKPB_PDATA_W-1:0]  pwdata,
    output logic [akpb_pkg::AKPB_PDATA_W-1:0]  prdata,
    output logic                               pready,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire  [7:0]                         i_chan_first,
    input  wire  [7:0]                         i_chan_second,
    input  wire  [7:0]                         i_chan_third,
    input  wire  [7:0]                         i_alpha,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic                               o_write_enable,
    output logic [akpb_pkg::AKPB_ADDR_W-1:0]   o_dest_address,
    output logic [7:0]                         o_out_byte0,
    output logic [7:0]                         o_out_byte1,
    output logic [7:0]                         o_out_byte2,
    output logic                               o_frame_last
);
    import akpb_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    akpb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    akpb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    akpb_dpath #(
        .MAX_DIM (MAX_DIM)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_chan_first   (i_chan_first),
        .i_chan_second  (i_chan_second),
        .i_chan_third   (i_chan_third),
        .i_alpha        (i_alpha),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_write_enable (o_write_enable),
        .o_dest_address (o_dest_address),
        .o_out_byte0    (o_out_byte0),
        .o_out_byte1    (o_out_byte1),
        .o_out_byte2    (o_out_byte2),
        .o_frame_last   (o_frame_last)
    );

endmodule
`default_nettype wire

// ----- verif/tb_alpha_keyed_pixel_blit_top.sv -----
`default_nettype none
module tb_alpha_keyed_pixel_blit_top;
    import akpb_pkg::*;

    localparam int          RANDOM_PIXELS = 2000;
    localparam int          DRAIN_CYCLES  = 12;
    localparam int unsigned CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic [7:0] chan_first;
        logic [7:0] chan_second;
        logic [7:0] chan_third;
        logic [7:0] alpha;
    } t_pixel;

    typedef struct {
        logic                   write_enable;
        logic [AKPB_ADDR_W-1:0] dest_address;
        logic [7:0]             byte0;
        logic [7:0]             byte1;
        logic [7:0]             byte2;
        logic                   frame_last;
    } t_pixel_write;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [AKPB_PADDR_W-1:0] paddr = '0;
    logic [AKPB_PDATA_W-1:0] pwdata = '0;
    logic [AKPB_PDATA_W-1:0] prdata;
    logic                    pready;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [7:0]              i_chan_first = '0;
    logic [7:0]              i_chan_second = '0;
    logic [7:0]              i_chan_third = '0;
    logic [7:0]              i_alpha = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic                    o_write_enable;
    logic [AKPB_ADDR_W-1:0]  o_dest_address;
    logic [7:0]              o_out_byte0;
    logic [7:0]              o_out_byte1;
    logic [7:0]              o_out_byte2;
    logic                    o_frame_last;

    // shadow of the register file and the raster walk
    t_cfg                    blit_cfg = AKPB_CFG_RESET;
    logic [AKPB_POS_W-1:0]   raster_col = '0;
    logic [AKPB_POS_W-1:0]   raster_row = '0;
    t_pixel_write            pending_writes[$];

    int                      failures = 0;
    int unsigned             cycle_count = 0;
    int                      burst_left = 8;
    bit                      sender_gaps_on = 1'b1;
    int                      hold_off_cycles = 0;
    t_stall_mode             stall_mode = STALL_NONE;
    int                      stall_mode_left = 0;
    int                      stall_phase = 0;

    alpha_keyed_pixel_blit_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_chan_first   (i_chan_first),
        .i_chan_second  (i_chan_second),
        .i_chan_third   (i_chan_third),
        .i_alpha        (i_alpha),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_write_enable (o_write_enable),
        .o_dest_address (o_dest_address),
        .o_out_byte0    (o_out_byte0),
        .o_out_byte1    (o_out_byte1),
        .o_out_byte2    (o_out_byte2),
        .o_frame_last   (o_frame_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("alpha_keyed_pixel_blit_top regression: fail");
            $finish;
        end
    end

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= 10) begin
            $display("%s", msg);
        end
    endtask

    // zero reads as one, anything past the maximum reads as the maximum
    function automatic longint unsigned eff_dim(input logic [AKPB_DIM_REG_W-1:0] v);
        if (v == 0) begin
            return 1;
        end
        if (v > AKPB_MAX_DIM) begin
            return AKPB_MAX_DIM;
        end
        return v;
    endfunction

    function automatic t_pixel_write predict_write(input t_pixel px);
        t_pixel_write    w;
        longint unsigned dw, dh, sw, sh, bpp, lim, addr, col, row, pos_x, pos_y;
        logic            col_end, row_end;
        dw    = eff_dim(blit_cfg.dest_width);
        dh    = eff_dim(blit_cfg.dest_height);
        sw    = eff_dim(blit_cfg.src_width);
        sh    = eff_dim(blit_cfg.src_height);
        bpp   = (blit_cfg.dest_bpp == AKPB_BPP_THREE) ? 3 : 4;
        col   = raster_col;
        row   = raster_row;
        pos_x = blit_cfg.place_x;
        pos_y = blit_cfg.place_y;
        lim   = dw * dh * bpp;
        addr  = (dw * (pos_y + row) + pos_x + col) * bpp;
        col_end = (col + 1) >= sw;
        row_end = (row + 1) >= sh;
        w.write_enable = (addr < lim) && (px.alpha != 8'h00);
        if (w.write_enable) begin
            w.dest_address = addr[AKPB_ADDR_W-1:0];
            w.byte0 = blit_cfg.swap_rb ? px.chan_third : px.chan_first;
            w.byte1 = px.chan_second;
            w.byte2 = blit_cfg.swap_rb ? px.chan_first : px.chan_third;
        end else begin
            w.dest_address = '0;
            w.byte0 = '0;
            w.byte1 = '0;
            w.byte2 = '0;
        end
        w.frame_last = col_end && row_end;
        // counters past a shrunk size wrap on the next advance
        if (col_end) begin
            raster_col = '0;
            raster_row = row_end ? '0 : raster_row + 1'b1;
        end else begin
            raster_col = raster_col + 1'b1;
        end
        return w;
    endfunction

    function automatic logic [AKPB_PDATA_W-1:0] reg_readback(input t_reg_idx idx);
        logic [AKPB_PDATA_W-1:0] v;
        v = '0;
        case (idx)
            REG_DEST_WIDTH:  v[AKPB_DIM_REG_W-1:0] = blit_cfg.dest_width;
            REG_DEST_HEIGHT: v[AKPB_DIM_REG_W-1:0] = blit_cfg.dest_height;
            REG_DEST_BPP:    v[AKPB_BPP_W-1:0]     = blit_cfg.dest_bpp;
            REG_SRC_WIDTH:   v[AKPB_DIM_REG_W-1:0] = blit_cfg.src_width;
            REG_SRC_HEIGHT:  v[AKPB_DIM_REG_W-1:0] = blit_cfg.src_height;
            REG_PLACE_X:     v[AKPB_POS_W-1:0]     = blit_cfg.place_x;
            REG_PLACE_Y:     v[AKPB_POS_W-1:0]     = blit_cfg.place_y;
            default:         v[0]                  = blit_cfg.swap_rb;
        endcase
        return v;
    endfunction

    // write one register, then read it straight back
    task automatic cfg_write(input t_reg_idx idx, input logic [AKPB_PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_DEST_WIDTH:  blit_cfg.dest_width  = value[AKPB_DIM_REG_W-1:0];
            REG_DEST_HEIGHT: blit_cfg.dest_height = value[AKPB_DIM_REG_W-1:0];
            REG_DEST_BPP:    blit_cfg.dest_bpp    = value[AKPB_BPP_W-1:0];
            REG_SRC_WIDTH:   blit_cfg.src_width   = value[AKPB_DIM_REG_W-1:0];
            REG_SRC_HEIGHT:  blit_cfg.src_height  = value[AKPB_DIM_REG_W-1:0];
            REG_PLACE_X:     blit_cfg.place_x     = value[AKPB_POS_W-1:0];
            REG_PLACE_Y:     blit_cfg.place_y     = value[AKPB_POS_W-1:0];
            default:         blit_cfg.swap_rb     = value[0];
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== reg_readback(idx)) begin
            report_failure($sformatf("register %s readback: expected %h, got %h",
                                     idx.name(), reg_readback(idx), prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [31:0] dw, input logic [31:0] dh,
                                input logic [31:0] bpp, input logic [31:0] sw,
                                input logic [31:0] sh, input logic [31:0] pos_x,
                                input logic [31:0] pos_y, input logic [31:0] swap);
        cfg_write(REG_DEST_WIDTH, dw);
        cfg_write(REG_DEST_HEIGHT, dh);
        cfg_write(REG_DEST_BPP, bpp);
        cfg_write(REG_SRC_WIDTH, sw);
        cfg_write(REG_SRC_HEIGHT, sh);
        cfg_write(REG_PLACE_X, pos_x);
        cfg_write(REG_PLACE_Y, pos_y);
        cfg_write(REG_SWAP_RB, swap);
    endtask

    task automatic send_pixel(input t_pixel px);
        int gap;
        i_valid       <= 1'b1;
        i_chan_first  <= px.chan_first;
        i_chan_second <= px.chan_second;
        i_chan_third  <= px.chan_third;
        i_alpha       <= px.alpha;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_writes.push_back(predict_write(px));
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            if (sender_gaps_on) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    task automatic wait_for_writes_drained();
        i_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_pixel rand_pixel();
        t_pixel px;
        int     pick;
        px.chan_first  = $urandom_range(0, 255);
        px.chan_second = $urandom_range(0, 255);
        px.chan_third  = $urandom_range(0, 255);
        pick = $urandom_range(0, 9);
        px.alpha = (pick < 2) ? 8'h00 : (pick == 2) ? 8'hFF : 8'($urandom_range(1, 255));
        return px;
    endfunction

    function automatic logic [31:0] pick_extreme_dim();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 1;
            2:       return AKPB_MAX_DIM;
            3:       return 8191;
            default: return $urandom_range(0, 8191);
        endcase
    endfunction

    // receiver: stall pattern switches among none, light, periodic and heavy modes
    always @(posedge i_clk) begin
        if (stall_mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(20, 300);
        end else begin
            stall_mode_left--;
        end
        stall_phase = (stall_phase == 6) ? 0 : stall_phase + 1;
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            i_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_NONE:     i_stall <= 1'b0;
                STALL_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: i_stall <= (stall_phase < 3);
                default:        i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_pixel_write got, want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            got.write_enable = o_write_enable;
            got.dest_address = o_dest_address;
            got.byte0        = o_out_byte0;
            got.byte1        = o_out_byte1;
            got.byte2        = o_out_byte2;
            got.frame_last   = o_frame_last;
            if (pending_writes.size() == 0) begin
                report_failure($sformatf("write beat with no pixel pending: we=%b addr=%h last=%b",
                                         got.write_enable, got.dest_address, got.frame_last));
            end else begin
                want = pending_writes.pop_front();
                if (got.write_enable !== want.write_enable ||
                    got.dest_address !== want.dest_address ||
                    got.byte0 !== want.byte0 || got.byte1 !== want.byte1 ||
                    got.byte2 !== want.byte2 || got.frame_last !== want.frame_last) begin
                    report_failure($sformatf(
                        "write mismatch: expected we=%b addr=%h bytes=%h %h %h last=%b, got we=%b addr=%h bytes=%h %h %h last=%b",
                        want.write_enable, want.dest_address, want.byte0, want.byte1,
                        want.byte2, want.frame_last, got.write_enable, got.dest_address,
                        got.byte0, got.byte1, got.byte2, got.frame_last));
                end
            end
        end
    end

    task automatic test_default_geometry();
        send_pixel('{8'h00, 8'h00, 8'h00, 8'h00});
        send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_pixel('{8'hA5, 8'h5A, 8'hC3, 8'h01});
        wait_for_writes_drained();
    endtask

    // source sits near the right edge so rows overrun onto the next and off the bottom
    task automatic test_overrun_wrap_and_swap();
        t_pixel px;
        set_geometry(8, 6, 3, 4, 3, 6, 4, 1);
        for (int i = 0; i < 10; i++) begin
            px.chan_first  = 8'(i * 8'h17);
            px.chan_second = ~px.chan_first;
            px.chan_third  = (i % 2) ? 8'hFF : 8'h00;
            px.alpha = (i == 3 || i == 8) ? 8'h00 : (i == 0) ? 8'h01 :
                       (i == 5) ? 8'h80 : 8'hFF;
            send_pixel(px);
        end
        wait_for_writes_drained();
    endtask

    task automatic test_clamped_registers();
        set_geometry(0, 8191, 7, 0, 5000, 4095, 4095, 0);
        send_pixel('{8'hFF, 8'h00, 8'hFF, 8'hFF});
        send_pixel('{8'h00, 8'hFF, 8'h00, 8'h7F});
        wait_for_writes_drained();
    endtask

    // last in-bounds pixel of the largest surface, then one pixel past it
    task automatic test_top_corner_address();
        set_geometry(AKPB_MAX_DIM, AKPB_MAX_DIM, 5, 8191, AKPB_MAX_DIM,
                     32'(4095 - raster_col), 32'(4095 - raster_row), 1);
        send_pixel('{8'h12, 8'h34, 8'h56, 8'hFF});
        send_pixel('{8'h9A, 8'hBC, 8'hDE, 8'hFF});
        wait_for_writes_drained();
    endtask

    task automatic test_size_change_mid_frame();
        set_geometry(16, 16, 4, 5, 4, 1, 1, 0);
        for (int i = 0; i < 5; i++) begin
            send_pixel(rand_pixel());
        end
        wait_for_writes_drained();
        cfg_write(REG_SRC_WIDTH, 2);
        cfg_write(REG_SRC_HEIGHT, 1);
        for (int i = 0; i < 3; i++) begin
            send_pixel(rand_pixel());
        end
        wait_for_writes_drained();
    endtask

    // receiver holds off long enough for the block to back up onto its input
    task automatic test_output_hold();
        set_geometry(20, 20, 4, 6, 5, 2, 3, 1);
        sender_gaps_on = 1'b0;
        hold_off_cycles = 80;
        for (int i = 0; i < 40; i++) begin
            send_pixel(rand_pixel());
        end
        wait_for_writes_drained();
        sender_gaps_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int              sent;
        int              count;
        longint unsigned frame_px;
        logic [31:0]     dw, dh, bpp, sw, sh, pos_x, pos_y;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            if ($urandom_range(0, 9) < 3) begin
                dw    = pick_extreme_dim();
                dh    = pick_extreme_dim();
                bpp   = $urandom_range(0, 7);
                sw    = ($urandom_range(0, 3) == 0) ? pick_extreme_dim() : $urandom_range(0, 20);
                sh    = ($urandom_range(0, 3) == 0) ? pick_extreme_dim() : $urandom_range(0, 20);
                pos_x = $urandom_range(0, 4095);
                pos_y = $urandom_range(0, 4095);
            end else begin
                dw    = $urandom_range(1, 48);
                dh    = $urandom_range(1, 48);
                bpp   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(3, 4);
                sw    = $urandom_range(1, 12);
                sh    = $urandom_range(1, 12);
                pos_x = $urandom_range(0, dw + 3);
                pos_y = $urandom_range(0, dh + 3);
            end
            set_geometry(dw, dh, bpp, sw, sh, pos_x, pos_y, $urandom_range(0, 1));
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            frame_px = eff_dim(blit_cfg.src_width) * eff_dim(blit_cfg.src_height);
            // mostly whole frames; now and then a cut-off run leaves the walk mid-frame
            if (frame_px > 200 || $urandom_range(0, 9) == 0) begin
                count = $urandom_range(20, 200);
            end else begin
                count = int'(frame_px) * ((160 / int'(frame_px)) > 0 ? 160 / int'(frame_px) : 1);
            end
            for (int i = 0; i < count; i++) begin
                send_pixel(rand_pixel());
            end
            sent += count;
            wait_for_writes_drained();
        end
        sender_gaps_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_geometry();
        test_overrun_wrap_and_swap();
        test_clamped_registers();
        test_top_corner_address();
        test_size_change_mid_frame();
        test_output_hold();
        test_random_frames();
        wait_for_writes_drained();
        if (failures == 0 && pending_writes.size() == 0) begin
            $display("alpha_keyed_pixel_blit_top regression: pass");
        end else begin
            $display("alpha_keyed_pixel_blit_top regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
src/akpb_pkg.sv
src/akpb_regs.sv
src/akpb_ctrl.sv
src/akpb_dpath.sv
src/alpha_keyed_pixel_blit_top.sv
verif/tb_alpha_keyed_pixel_blit_top.sv
